@@ rtl/core/jsu_pkg.sv @@
package jsu_pkg;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX,
        MODE_HELD,
        MODE_HELD_ESC,
        MODE_LOW_HEX
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    // most results one input byte can cause
    localparam int RUN_MAX = 6;
    localparam int RUN_W   = 3;

    // characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // surrogate ranges and plane offset
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;

    // utf-8 encoding of one code point
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] data;
    } utf8_t;

    // hex digit decode
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexd_t;

    // simple escape decode
    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } escm_t;

    // one run of results queued between front and back
    typedef struct packed {
        logic [RUN_W-1:0]          nd;
        logic [RUN_MAX-1:0][7:0]   data;
        status_t                   tail;
    } jsu_entry_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.len  = 3'd0;
        r.data = '0;
        if (cp < 21'h80)
        begin
            r.len     = 3'd1;
            r.data[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            r.len     = 3'd2;
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.len     = 3'd3;
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.len     = 3'd4;
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hexd_t hex_decode(input logic [7:0] c);
        hexd_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
            r.val = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r.val = c[3:0] + 4'd9;
        else
            r.ok = 1'b0;
        return r;
    endfunction

    function automatic escm_t esc_map(input logic [7:0] c);
        escm_t r;
        r.ok  = 1'b1;
        r.val = 8'h00;
        case (c)
            CH_QUOTE:  r.val = CH_QUOTE;
            CH_BSLASH: r.val = CH_BSLASH;
            CH_SLASH:  r.val = CH_SLASH;
            CH_LOW_B:  r.val = CH_BS;
            CH_LOW_F:  r.val = CH_FF;
            CH_LOW_N:  r.val = CH_LF;
            CH_LOW_R:  r.val = CH_CR;
            CH_LOW_T:  r.val = CH_TAB;
            default:   r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/jsu_front.sv @@
module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               end_of_text,
    input  logic               q_full,
    output logic               q_push,
    output jsu_pkg::jsu_entry_t q_entry
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  dc_reg, dc_next;
    logic [9:0]  held_reg, held_next;

    logic        accept;
    logic        fail, closed, pre_held;
    logic        do_body, do_esc, do_digit, low_phase;
    logic        digit_done;
    logic [15:0] acc;
    hexd_t       hd;
    escm_t       em;
    utf8_t       main_enc, held_enc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hex_reg  <= '0;
            dc_reg   <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            dc_reg   <= dc_next;
            held_reg <= held_next;
        end
    end

    assign hd       = hex_decode(in_byte);
    assign em       = esc_map(in_byte);
    assign acc      = {hex_reg[11:0], hd.val};
    assign held_enc = utf8_encode({5'd0, HI_SURR_TAG, held_reg});

    // classify the byte and work out the run it causes
    always_comb
    begin
        mode_next  = mode_reg;
        hex_next   = hex_reg;
        dc_next    = dc_reg;
        held_next  = held_reg;
        fail       = 1'b0;
        closed     = 1'b0;
        pre_held   = 1'b0;
        do_body    = 1'b0;
        do_esc     = 1'b0;
        do_digit   = 1'b0;
        low_phase  = 1'b0;
        digit_done = 1'b0;
        main_enc   = '0;

        case (mode_reg)
            MODE_BODY:
                do_body = 1'b1;
            MODE_ESC:
                do_esc = 1'b1;
            MODE_HEX:
                do_digit = 1'b1;
            MODE_HELD:
            begin
                if (in_byte == CH_BSLASH)
                    mode_next = MODE_HELD_ESC;
                else
                begin
                    pre_held  = 1'b1;
                    mode_next = MODE_BODY;
                    do_body   = 1'b1;
                end
            end
            MODE_HELD_ESC:
            begin
                if (in_byte == CH_LOW_U)
                begin
                    hex_next  = '0;
                    dc_next   = '0;
                    mode_next = MODE_LOW_HEX;
                end
                else
                begin
                    pre_held = 1'b1;
                    do_esc   = 1'b1;
                end
            end
            MODE_LOW_HEX:
            begin
                do_digit  = 1'b1;
                low_phase = 1'b1;
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                    mode_next = MODE_BODY;
                else
                    fail = 1'b1;
            end
        endcase

        // plain string body byte
        if (do_body)
        begin
            if (in_byte == CH_QUOTE)
                closed = 1'b1;
            else if (in_byte == CH_BSLASH)
                mode_next = MODE_ESC;
            else
            begin
                main_enc.len     = 3'd1;
                main_enc.data[0] = in_byte;
            end
        end

        // byte after a backslash
        if (do_esc)
        begin
            mode_next = MODE_BODY;
            if (in_byte == CH_LOW_U)
            begin
                hex_next  = '0;
                dc_next   = '0;
                mode_next = MODE_HEX;
            end
            else if (em.ok)
            begin
                main_enc.len     = 3'd1;
                main_enc.data[0] = em.val;
            end
            else
                fail = 1'b1;
        end

        // hex digit of a \u escape
        if (do_digit)
        begin
            if (!hd.ok)
                fail = 1'b1;
            else
            begin
                hex_next = acc;
                if (dc_reg == 2'd3)
                begin
                    dc_next    = '0;
                    digit_done = 1'b1;
                end
                else
                    dc_next = dc_reg + 2'd1;
            end
        end

        // four digits gathered
        if (digit_done)
        begin
            if (low_phase && acc inside {[LO_SURR_MIN:LO_SURR_MAX]})
            begin
                main_enc  = utf8_encode(PLANE1_BASE + {1'b0, held_reg, acc[9:0]});
                mode_next = MODE_BODY;
            end
            else
            begin
                pre_held = low_phase;
                if (acc inside {[HI_SURR_MIN:HI_SURR_MAX]})
                begin
                    held_next = acc[9:0];
                    mode_next = MODE_HELD;
                end
                else
                begin
                    main_enc  = utf8_encode({5'd0, acc});
                    mode_next = MODE_BODY;
                end
            end
        end

        // text ran out inside a string
        if (!fail && !closed && end_of_text && mode_next != MODE_IDLE)
            fail = 1'b1;

        // string finished either way
        if (fail || closed)
        begin
            mode_next = MODE_IDLE;
            hex_next  = '0;
            dc_next   = '0;
            held_next = '0;
        end
    end

    // build the queued run
    always_comb
    begin
        if (pre_held)
        begin
            q_entry.data = {main_enc.data[2], main_enc.data[1], main_enc.data[0],
                            held_enc.data[2], held_enc.data[1], held_enc.data[0]};
            q_entry.nd   = 3'd3 + main_enc.len;
        end
        else
        begin
            q_entry.data = {16'h0000, main_enc.data};
            q_entry.nd   = main_enc.len;
        end
        q_entry.tail = closed ? ST_DONE : ST_DATA;
        if (fail)
        begin
            q_entry.nd   = '0;
            q_entry.tail = ST_ERROR;
        end
    end

    assign q_push = accept && (q_entry.nd != '0 || q_entry.tail != ST_DATA);

endmodule

@@ rtl/core/jsu_queue.sv @@
module jsu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsu_pkg::jsu_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output jsu_pkg::jsu_entry_t head_entry
);
    import jsu_pkg::*;

    jsu_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/core/jsu_back.sv @@
module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  jsu_pkg::jsu_entry_t head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic [1:0]          status,
    output logic                last_in_run
);
    import jsu_pkg::*;

    jsu_entry_t        cur_reg;
    logic              cur_valid_reg, cur_valid_next;
    logic [RUN_W-1:0]  idx_reg, idx_next;
    logic [RUN_W-1:0]  cnt_reg;
    logic              fire, load;

    assign out_valid   = cur_valid_reg;
    assign last_in_run = (idx_reg == cnt_reg - 3'd1);
    assign fire        = cur_valid_reg && !out_stall;
    assign load        = !cur_valid_reg || (fire && last_in_run);
    assign pop         = load && head_valid;

    // result of the current run
    always_comb
    begin
        if (idx_reg < cur_reg.nd)
        begin
            out_byte = cur_reg.data[idx_reg];
            status   = ST_DATA;
        end
        else
        begin
            out_byte = 8'h00;
            status   = cur_reg.tail;
        end
    end

    // run sequencing
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = head_valid;
            idx_next       = '0;
        end
        else if (fire)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // run payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_entry;
            cnt_reg <= head_entry.nd + {2'b00, head_entry.tail != ST_DATA};
        end
    end

endmodule

@@ rtl/core/json_string_unescape_utf8_unit.sv @@
// json string unescaper: raw bytes of one json string token in, utf-8 bytes out
// input channel: in_valid / in_stall, payload in_byte and end_of_text; a byte
//   transfers on a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall, payload out_byte, status and
//   last_in_run; status is data byte, string complete, or malformed string
// each input byte causes zero to six results; last_in_run marks the final one
// latency: a byte's run is registered in the queue, then loaded into the output
//   sequencer, where out_valid rises for its first result
// throughput: one input byte per cycle while each byte causes at most one
//   result and out_stall stays low; a byte that causes more results holds the
//   one-result-per-cycle output sequencer until its last result transfers
// the front scanner, while the queue has room, decodes one byte per cycle into
//   a run for a two-entry queue; the back sequencer sends one result per cycle
//   while out_stall is low; when it is high the queue fills and in_stall rises
//   once two runs wait behind the run being played out
// in_stall depends only on queue fill, never on in_valid
// reset: scanner waits for an opening quote, queue and output are empty
module json_string_unescape_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last_in_run
);
    import jsu_pkg::*;

    logic       q_full, q_push, q_pop, q_head_valid;
    jsu_entry_t q_entry, q_head;

    // byte scanner
    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // run queue
    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // result sequencer
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_entry  (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_in_run (last_in_run)
    );

endmodule

@@ tb/sv/json_string_unescape_utf8_unit_test.sv @@
`timescale 1ns / 100ps

module json_string_unescape_utf8_unit_test;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_REPORTS   = 10;
    // row result count meaning "let the decoder model work it out"
    localparam int PREDICTED     = -1;

    // one decoded result as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        status_t    st;
        logic       last;
    } result_t;

    // one input byte, with an optional hand-typed result
    typedef struct {
        logic [7:0] b;
        logic       eot;
        int         n;
        logic [7:0] data;
        status_t    st;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_in_run;

    // decoder model state
    mode_t       scan_st = MODE_IDLE;
    logic [15:0] acc = 16'h0000;
    logic [1:0]  ndig = 2'd0;
    logic [9:0]  held_hi = 10'd0;
    bit          str_bad;
    bit          str_closed;
    logic [7:0]  utf8_buf[$];
    result_t     run_q[$];

    result_t     decoded_due_q[$];
    stim_row_t   stim_q[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    json_string_unescape_utf8_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_in_run (last_in_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("json_string_unescape_utf8_unit_test: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    task clear_scanner;
        scan_st = MODE_IDLE;
        acc     = 16'h0000;
        ndig    = 2'd0;
        held_hi = 10'd0;
    endtask

    // append one decoded byte
    task queue_byte(input logic [7:0] v);
        utf8_buf = {utf8_buf, v};
    endtask

    // append one result of the current byte
    task queue_result(input logic [7:0] d, input status_t st);
        result_t res;
        res.data = d;
        res.st   = st;
        res.last = 1'b0;
        run_q    = {run_q, res};
    endtask

    // utf-8 bytes of one code point
    task put_cp(input logic [20:0] cp);
        int         n;
        logic [7:0] lead;
        if (cp < 21'h80)
        begin
            queue_byte(cp[7:0]);
            return;
        end
        n    = (cp < 21'h800) ? 1 : (cp < 21'h10000) ? 2 : 3;
        lead = (n == 1) ? 8'hC0 : (n == 2) ? 8'hE0 : 8'hF0;
        queue_byte(lead | 8'(cp >> (6 * n)));
        for (int i = n - 1; i >= 0; i--)
            queue_byte(8'h80 | 8'((cp >> (6 * i)) & 21'h3F));
    endtask

    task body_char(input logic [7:0] c);
        if (c == CH_QUOTE)
            str_closed = 1'b1;
        else if (c == CH_BSLASH)
            scan_st = MODE_ESC;
        else
            queue_byte(c);
    endtask

    task escape_char(input logic [7:0] c);
        scan_st = MODE_BODY;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: queue_byte(c);
            CH_LOW_B: queue_byte(CH_BS);
            CH_LOW_F: queue_byte(CH_FF);
            CH_LOW_N: queue_byte(CH_LF);
            CH_LOW_R: queue_byte(CH_CR);
            CH_LOW_T: queue_byte(CH_TAB);
            CH_LOW_U:
            begin
                acc     = 16'h0000;
                ndig    = 2'd0;
                scan_st = MODE_HEX;
            end
            default: str_bad = 1'b1;
        endcase
    endtask

    // gathers one hex digit, fourth goes high once four are in
    task hex_digit(input logic [7:0] c, output bit fourth);
        logic [3:0] v;
        fourth = 1'b0;
        if (c inside {[8'h30:8'h39]})
            v = 4'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            v = 4'(c - 8'h37);
        else if (c inside {[8'h61:8'h66]})
            v = 4'(c - 8'h57);
        else
        begin
            str_bad = 1'b1;
            return;
        end
        acc = {acc[11:0], v};
        if (ndig == 2'd3)
        begin
            ndig   = 2'd0;
            fourth = 1'b1;
        end
        else
            ndig = ndig + 2'd1;
    endtask

    // a high surrogate waits for its partner, anything else goes out
    task finish_cp(input logic [15:0] cp);
        if (cp >= HI_SURR_MIN && cp <= HI_SURR_MAX)
        begin
            held_hi = cp[9:0];
            scan_st = MODE_HELD;
        end
        else
        begin
            put_cp({5'd0, cp});
            scan_st = MODE_BODY;
        end
    endtask

    // results that one input byte causes, left in run_q
    task unescape_byte(input logic [7:0] b, input logic eot);
        bit fourth;
        str_bad    = 1'b0;
        str_closed = 1'b0;
        utf8_buf.delete();
        run_q.delete();
        case (scan_st)
            MODE_BODY: body_char(b);
            MODE_ESC:  escape_char(b);
            MODE_HEX:
            begin
                hex_digit(b, fourth);
                if (fourth)
                    finish_cp(acc);
            end
            MODE_HELD:
            begin
                if (b == CH_BSLASH)
                    scan_st = MODE_HELD_ESC;
                else
                begin
                    put_cp({5'd0, HI_SURR_TAG, held_hi});
                    scan_st = MODE_BODY;
                    body_char(b);
                end
            end
            MODE_HELD_ESC:
            begin
                if (b == CH_LOW_U)
                begin
                    acc     = 16'h0000;
                    ndig    = 2'd0;
                    scan_st = MODE_LOW_HEX;
                end
                else
                begin
                    put_cp({5'd0, HI_SURR_TAG, held_hi});
                    escape_char(b);
                end
            end
            MODE_LOW_HEX:
            begin
                hex_digit(b, fourth);
                if (fourth)
                begin
                    if (acc >= LO_SURR_MIN && acc <= LO_SURR_MAX)
                    begin
                        put_cp(PLANE1_BASE + {1'b0, held_hi, acc[9:0]});
                        scan_st = MODE_BODY;
                    end
                    else
                    begin
                        put_cp({5'd0, HI_SURR_TAG, held_hi});
                        finish_cp(acc);
                    end
                end
            end
            default:
            begin
                if (b == CH_QUOTE)
                    scan_st = MODE_BODY;
                else
                    str_bad = 1'b1;
            end
        endcase

        // text ran out before the closing quote
        if (!str_bad && !str_closed && eot && scan_st != MODE_IDLE)
            str_bad = 1'b1;

        if (str_bad)
        begin
            clear_scanner();
            queue_result(8'h00, ST_ERROR);
        end
        else
        begin
            foreach (utf8_buf[i])
                queue_result(utf8_buf[i], ST_DATA);
            if (str_closed)
            begin
                clear_scanner();
                queue_result(8'h00, ST_DONE);
            end
        end
        if (run_q.size() > 0)
            run_q[$].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task add_row(input logic [7:0] b, input logic eot = 1'b0, input int n = PREDICTED,
                 input logic [7:0] data = 8'h00, input status_t st = ST_DATA);
        stim_row_t r;
        r.b    = b;
        r.eot  = eot;
        r.n    = n;
        r.data = data;
        r.st   = st;
        stim_q = {stim_q, r};
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + v;
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    task add_u(input logic [15:0] cp);
        add_row(CH_BSLASH);
        add_row(CH_LOW_U);
        for (int i = 3; i >= 0; i--)
            add_row(hex_char(cp[4 * i +: 4]));
    endtask

    // sender gap after a transfer: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drive one byte, hold it until it transfers, then log what it should cause
    task automatic send_row(input stim_row_t r);
        int      gap;
        result_t want;
        in_valid    <= 1'b1;
        in_byte     <= r.b;
        end_of_text <= r.eot;
        do
            @(posedge clk);
        while (in_stall);
        unescape_byte(r.b, r.eot);
        if (r.n == PREDICTED)
            decoded_due_q = {decoded_due_q, run_q};
        else if (r.n == 1)
        begin
            want.data     = r.data;
            want.st       = r.st;
            want.last     = 1'b1;
            decoded_due_q = {decoded_due_q, want};
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // receiver stall: runs of ready, short stalls, now and then a long one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end
            else if (r < 90)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    task note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // compare each output transfer with the oldest decoded result due
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_due_q.size() == 0)
                note_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                        out_byte, status, last_in_run));
            else
            begin
                want = decoded_due_q.pop_front();
                if (out_byte !== want.data || status !== want.st ||
                    last_in_run !== want.last)
                    note_mismatch($sformatf(
                        "expected byte %02h status %0d last %0b, got %02h %0d %0b",
                        want.data, want.st, want.last, out_byte, status, last_in_run));
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        logic [7:0]  b;
        logic [7:0]  esc_letters[8];
        int          items_sent;
        int          ntok;
        int          kind;

        esc_letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                        CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: stray byte out of reset, byte extremes, bad escape
        add_row("A", 1'b0, 1, 8'h00, ST_ERROR);
        add_row(CH_QUOTE, 1'b0, 0);
        add_row(8'h00, 1'b0, 1, 8'h00, ST_DATA);
        add_row(8'hFF, 1'b0, 1, 8'hFF, ST_DATA);
        add_row(CH_BSLASH, 1'b0, 0);
        add_row("q", 1'b0, 1, 8'h00, ST_ERROR);
        // top surrogate pair, a held high surrogate broken by a plain byte, a bad hex digit
        add_text("\"\\uDBFF\\uDFFF\\uD800x\\u12");
        add_row("g", 1'b0, 1, 8'h00, ST_ERROR);
        // text ends inside a string, and on an opening quote
        add_row(CH_QUOTE, 1'b0, 0);
        add_row("a", 1'b1, 1, 8'h00, ST_ERROR);
        add_row(CH_QUOTE, 1'b1, 1, 8'h00, ST_ERROR);
        // empty string closed on the last byte of the text
        add_row(CH_QUOTE, 1'b0, 0);
        add_row(CH_QUOTE, 1'b1, 1, 8'h00, ST_DONE);
        items_sent = stim_q.size();
        while (stim_q.size() > 0)
            send_row(stim_q.pop_front());

        // random strings, mostly well formed
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
            add_row(CH_QUOTE);
            for (int t = 0; t < ntok; t++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 4)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    add_row(b);
                end
                else if (kind == 4)
                begin
                    add_row(CH_BSLASH);
                    add_row(esc_letters[$urandom_range(0, 7)]);
                end
                else
                begin
                    // code point sizes, surrogate pairs and lone surrogates
                    case ($urandom_range(0, 5))
                        0: add_u(16'($urandom_range(16'h0000, 16'h007F)));
                        1: add_u(16'($urandom_range(16'h0080, 16'h07FF)));
                        2: add_u(16'($urandom_range(16'h0800, 16'hFFFF)));
                        3:
                        begin
                            add_u(HI_SURR_MIN + 16'($urandom_range(0, 1023)));
                            add_u(LO_SURR_MIN + 16'($urandom_range(0, 1023)));
                        end
                        4: add_u(LO_SURR_MIN + 16'($urandom_range(0, 1023)));
                        default: add_u(HI_SURR_MIN + 16'($urandom_range(0, 1023)));
                    endcase
                end
            end

            // ending: usually a clean close, sometimes a broken string
            if ($urandom_range(0, 5) != 0)
                add_row(CH_QUOTE, ($urandom_range(0, 3) == 0));
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        add_row(CH_BSLASH);
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
                                         CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U});
                        add_row(b);
                    end
                    1:
                    begin
                        add_row(CH_BSLASH);
                        add_row(CH_LOW_U);
                        repeat ($urandom_range(0, 3))
                            add_row(hex_char(4'($urandom_range(0, 15))));
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
                        add_row(b);
                    end
                    2: add_row(8'($urandom_range(0, 255)), 1'b1);
                    default:
                    begin
                        add_row(CH_QUOTE);
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE);
                        add_row(b);
                    end
                endcase
            end

            items_sent += stim_q.size();
            while (stim_q.size() > 0)
                send_row(stim_q.pop_front());
        end

        in_valid <= 1'b0;
        calm = 1'b0;
        while (decoded_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("json_string_unescape_utf8_unit_test: PASS");
        else
            $display("json_string_unescape_utf8_unit_test: FAIL");
        $finish;
    end

endmodule
